// File: rtl/core/bao_pkg.sv
// ----------------------------------------------------------------------------
// bao_pkg
// Shared constants, register indexes and the lane status type of the
// burst-average overcurrent trip block.
// ----------------------------------------------------------------------------
package bao_pkg;

	// defaults for the top-level parameters
	localparam int MAX_SAMPLES_DEF       = 64;
	localparam int SAMPLE_BITS_DEF       = 12;
	localparam int HAS_SECOND_OUTPUT_DEF = 1;

	// fixed field widths
	localparam int SCALE_W    = 24;
	localparam int CURRENT_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

	// register reset values
	localparam logic [SCALE_W-1:0]   SCALE_RST     = 24'd65536;
	localparam logic [CURRENT_W-1:0] THRESHOLD_RST = 16'hFFFF;

	localparam logic [CURRENT_W-1:0] CURRENT_SAT = 16'hFFFF;

	// what one lane reports to the merging stage
	typedef struct packed {
		logic                 done;
		logic [CURRENT_W-1:0] current_ma;
	} lane_status_t;

endpackage

// File: rtl/core/bao_lane.sv
// ----------------------------------------------------------------------------
// bao_lane
// One channel: accumulates good samples of a burst, then divides the sum by
// the count one quotient bit per cycle, scales to milliamps and holds it.
// ----------------------------------------------------------------------------
module bao_lane import bao_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   acc_en,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   err,
	input  logic                   start,
	input  logic [SCALE_W-1:0]     scale,
	output lane_status_t           status
);

	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int STEP_W = $clog2(SUM_W);
	localparam int PROD_W = SAMPLE_BITS + SCALE_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_RND  = 2'd3;

	logic [1:0]           state_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;
	logic [STEP_W-1:0]    step_q;
	logic [PROD_W-1:0]    prod_q;
	logic [CURRENT_W-1:0] held_q;
	logic                 done_q;

	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    trial_sub;
	logic              fits;
	logic [PROD_W:0]   rounded;
	logic              ovf;

	// restoring divide step
	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign fits      = trial >= {1'b0, div_q};

	assign rounded = {1'b0, prod_q} + (PROD_W+1)'(32768);
	assign ovf     = |rounded[PROD_W:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
			held_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// empty channel keeps its held current
					done_q <= start && cnt_q == '0;
					if (start) begin
						if (cnt_q != '0) begin
							state_q <= ST_DIV;
						end
						sum_q <= '0;
						cnt_q <= '0;
					end else if (acc_en && !err && cnt_q < CNT_W'(MAX_SAMPLES)) begin
						sum_q <= sum_q + SUM_W'(sample);
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DIV: begin
					done_q <= 1'b0;
					if (step_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					done_q  <= 1'b0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					held_q  <= ovf ? CURRENT_SAT : rounded[31:16];
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q  <= sum_q;
				rem_q  <= '0;
				div_q  <= cnt_q;
				step_q <= STEP_W'(SUM_W - 1);
			end
			ST_DIV: begin
				quo_q  <= {quo_q[SUM_W-2:0], fits};
				rem_q  <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
				step_q <= step_q - STEP_W'(1);
			end
			ST_MUL: begin
				// the average never exceeds the largest sample
				prod_q <= PROD_W'(quo_q[SAMPLE_BITS-1:0]) * PROD_W'(scale);
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	assign status.done       = done_q;
	assign status.current_ma = held_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_q != '0)
		else $error("divide running with zero count");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RND |=> done_q && state_q == ST_IDLE)
		else $error("lane did not finish after rounding");

endmodule

// File: rtl/core/bao_merge.sv
// ----------------------------------------------------------------------------
// bao_merge
// Waits for every lane to finish, compares the currents with the trip level
// and loads the output register.
// ----------------------------------------------------------------------------
module bao_merge import bao_pkg::*; #(
	parameter int HAS_SECOND_OUTPUT = HAS_SECOND_OUTPUT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_status_t         lane_a,
	input  lane_status_t         lane_b,
	input  logic [CURRENT_W-1:0] threshold,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [CURRENT_W-1:0] current_a_ma,
	output logic [CURRENT_W-1:0] current_b_ma,
	output logic                 trip_a,
	output logic                 trip_b,
	output logic                 emit
);

	logic [1:0] done_q;
	logic [1:0] done_all;
	logic       valid_q;

	assign done_all = done_q | {lane_b.done, lane_a.done};
	assign emit     = (&done_all) && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			done_q <= emit ? 2'b00 : done_all;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			current_a_ma <= lane_a.current_ma;
			trip_a       <= lane_a.current_ma >= threshold;
			if (HAS_SECOND_OUTPUT != 0) begin
				current_b_ma <= lane_b.current_ma;
				trip_b       <= lane_b.current_ma >= threshold;
			end else begin
				current_b_ma <= '0;
				trip_b       <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;

endmodule

// File: rtl/core/burst_average_overcurrent_trip_top.sv
// ----------------------------------------------------------------------------
// burst_average_overcurrent_trip_top
// Per-channel burst averaging of ADC scans with milliamp scaling and trip.
// ----------------------------------------------------------------------------
// A scan word without burst_end is taken while in_stall is low and only
// accumulates. A word with burst_end starts the end-of-burst calculation:
// each channel lane divides its sum by its count with a restoring divider,
// one quotient bit per cycle, then multiplies and rounds; when neither
// channel has a good sample in the burst, the lanes skip the divide and
// keep their held currents. in_stall stays high from the start of the
// calculation until the result enters the output register; the output
// register then holds the result while a new burst accumulates. The user
// must write registers only while the block is idle; the block does not enforce this.
module burst_average_overcurrent_trip_top import bao_pkg::*; #(
	parameter int MAX_SAMPLES       = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
	parameter int HAS_SECOND_OUTPUT = HAS_SECOND_OUTPUT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample_a,
	input  logic                   error_a,
	input  logic [SAMPLE_BITS-1:0] sample_b,
	input  logic                   error_b,
	input  logic                   burst_end,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CURRENT_W-1:0]   current_a_ma,
	output logic [CURRENT_W-1:0]   current_b_ma,
	output logic                   trip_a,
	output logic                   trip_b
);

	logic [SCALE_W-1:0]   scale_q;
	logic [CURRENT_W-1:0] threshold_q;
	logic                 busy_q;
	logic                 start_q;
	logic                 accept;
	logic                 emit;
	lane_status_t         lane_a;
	lane_status_t         lane_b;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				REG_THRESHOLD: threshold_q <= cfg_data[CURRENT_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= accept && burst_end;
			if (accept && burst_end) begin
				busy_q <= 1'b1;
			end else if (emit) begin
				busy_q <= 1'b0;
			end
		end
	end

	bao_lane #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_a (
		.clk    (clk),
		.arst_n (arst_n),
		.acc_en (accept),
		.sample (sample_a),
		.err    (error_a),
		.start  (start_q),
		.scale  (scale_q),
		.status (lane_a)
	);

	generate
		if (HAS_SECOND_OUTPUT != 0) begin : g_lane_b
			bao_lane #(
				.MAX_SAMPLES (MAX_SAMPLES),
				.SAMPLE_BITS (SAMPLE_BITS)
			) u_lane_b (
				.clk    (clk),
				.arst_n (arst_n),
				.acc_en (accept),
				.sample (sample_b),
				.err    (error_b),
				.start  (start_q),
				.scale  (scale_q),
				.status (lane_b)
			);
		end else begin : g_no_lane_b
			// absent channel finishes with channel A and reads as zero
			assign lane_b.done       = lane_a.done;
			assign lane_b.current_ma = '0;
		end
	endgenerate

	bao_merge #(
		.HAS_SECOND_OUTPUT (HAS_SECOND_OUTPUT)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.lane_a       (lane_a),
		.lane_b       (lane_b),
		.threshold    (threshold_q),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.current_a_ma (current_a_ma),
		.current_b_ma (current_b_ma),
		.trip_a       (trip_a),
		.trip_b       (trip_b),
		.emit         (emit)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && burst_end |=> busy_q && start_q)
		else $error("end of burst did not start the calculation");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> busy_q && !start_q)
		else $error("result produced outside a calculation");

	assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> busy_q && !emit)
		else $error("calculation started while idle");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the burst-average overcurrent trip block against its own model of
// per-channel accumulation, truncating average, rounded milliamp scaling,
// saturation and trip flags, with random idling on the input and output sides.
// ----------------------------------------------------------------------------
module testbench;
	import bao_pkg::*;

	localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
	localparam int SUM_W           = SAMPLE_W + $clog2(MAX_SAMPLES_DEF);
	localparam int COUNT_W         = $clog2(MAX_SAMPLES_DEF) + 1;
	localparam int SETTLE_CYCLES   = 2 * (SAMPLE_W + $clog2(MAX_SAMPLES_DEF) + 4);
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int MAX_REPORTED    = 10;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	typedef struct packed {
		logic [CURRENT_W-1:0] current_a;
		logic [CURRENT_W-1:0] current_b;
		logic                 trip_a;
		logic                 trip_b;
	} burst_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   sample_a;
	logic                  error_a;
	logic [SAMPLE_W-1:0]   sample_b;
	logic                  error_b;
	logic                  burst_end;
	logic                  out_valid;
	logic                  out_stall;
	logic [CURRENT_W-1:0]  current_a_ma;
	logic [CURRENT_W-1:0]  current_b_ma;
	logic                  trip_a;
	logic                  trip_b;

	// model state, starting from the reset values
	logic [SCALE_W-1:0]   scale_q16    = SCALE_RST;
	logic [CURRENT_W-1:0] threshold_ma = THRESHOLD_RST;
	logic [SUM_W-1:0]     sum_a        = '0;
	logic [SUM_W-1:0]     sum_b        = '0;
	logic [COUNT_W-1:0]   count_a      = '0;
	logic [COUNT_W-1:0]   count_b      = '0;
	logic [CURRENT_W-1:0] held_a       = '0;
	logic [CURRENT_W-1:0] held_b       = '0;

	burst_report_t expected_reports[$];

	bit tx_idling     = 1'b0;
	bit rx_idling     = 1'b0;
	bit hold_request  = 1'b0;
	bit hold_active   = 1'b0;
	int mismatch_count  = 0;
	int reports_checked = 0;
	int scans_sent      = 0;
	int trips_seen      = 0;
	int saturated_seen  = 0;
	int in_stall_cycles = 0;

	burst_average_overcurrent_trip_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_a     (sample_a),
		.error_a      (error_a),
		.sample_b     (sample_b),
		.error_b      (error_b),
		.burst_end    (burst_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.current_a_ma (current_a_ma),
		.current_b_ma (current_b_ma),
		.trip_a       (trip_a),
		.trip_b       (trip_b)
	);

	always #5 clk = ~clk;

	function automatic logic [CURRENT_W-1:0] average_to_ma(input logic [SUM_W-1:0] sum,
			input logic [COUNT_W-1:0] count);
		logic [63:0] avg;
		logic [63:0] ma;
		avg = 64'(sum) / 64'(count);
		// round half up, then clamp
		ma = (avg * 64'(scale_q16) + 64'd32768) >> 16;
		return (ma > 64'(CURRENT_SAT)) ? CURRENT_SAT : ma[CURRENT_W-1:0];
	endfunction

	task automatic accumulate_scan(input logic [SAMPLE_W-1:0] sa, input logic ea,
			input logic [SAMPLE_W-1:0] sb, input logic eb, input logic be);
		burst_report_t rep;
		if (!ea && count_a < MAX_SAMPLES_DEF) begin
			sum_a += SUM_W'(sa);
			count_a++;
		end
		if (HAS_SECOND_OUTPUT_DEF != 0 && !eb && count_b < MAX_SAMPLES_DEF) begin
			sum_b += SUM_W'(sb);
			count_b++;
		end
		if (!be)
			return;
		if (count_a != 0)
			held_a = average_to_ma(sum_a, count_a);
		if (HAS_SECOND_OUTPUT_DEF != 0 && count_b != 0)
			held_b = average_to_ma(sum_b, count_b);
		rep.current_a = held_a;
		rep.trip_a    = (held_a >= threshold_ma);
		if (HAS_SECOND_OUTPUT_DEF != 0) begin
			rep.current_b = held_b;
			rep.trip_b    = (held_b >= threshold_ma);
		end else begin
			rep.current_b = '0;
			rep.trip_b    = 1'b0;
		end
		expected_reports.push_back(rep);
		sum_a   = '0;
		sum_b   = '0;
		count_a = '0;
		count_b = '0;
	endtask

	// leaves in_valid high so back-to-back words need no second assignment
	task automatic send_scan(input logic [SAMPLE_W-1:0] sa, input logic ea,
			input logic [SAMPLE_W-1:0] sb, input logic eb, input logic be);
		int gap;
		gap = (tx_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_a  <= sa;
		error_a   <= ea;
		sample_b  <= sb;
		error_b   <= eb;
		burst_end <= be;
		do @(posedge clk); while (in_stall);
		accumulate_scan(sa, ea, sb, eb, be);
		scans_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SCALE:     scale_q16 = data[SCALE_W-1:0];
			REG_THRESHOLD: threshold_ma = data[CURRENT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SAMPLE_MAX;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic int pick_error_rate();
		case ($urandom_range(0, 7))
			0: return 100;
			1, 2: return 30;
			default: return 0;
		endcase
	endfunction

	task automatic send_burst(input int len, input int pct_a, input int pct_b);
		for (int i = 0; i < len; i++)
			send_scan(pick_sample(), $urandom_range(0, 99) < pct_a,
				pick_sample(), $urandom_range(0, 99) < pct_b, i == len - 1);
	endtask

	task automatic test_directed_extremes();
		send_scan('0, 1'b0, '0, 1'b0, 1'b1);
		send_scan(SAMPLE_MAX, 1'b0, SAMPLE_MAX, 1'b0, 1'b1);
		// channel a empty keeps its held current
		send_scan(12'h555, 1'b1, 12'hAAA, 1'b0, 1'b1);
		send_scan('0, 1'b1, '0, 1'b1, 1'b1);
		send_scan(12'hAAA, 1'b0, 12'h001, 1'b1, 1'b0);
		send_scan(12'h555, 1'b0, 12'h002, 1'b0, 1'b0);
		send_scan(12'h000, 1'b1, 12'h003, 1'b0, 1'b1);
		// truncating average
		send_scan(12'd1, 1'b0, SAMPLE_MAX, 1'b0, 1'b0);
		send_scan(12'd2, 1'b0, SAMPLE_MAX - 1'b1, 1'b0, 1'b1);
		settle();
	endtask

	task automatic test_register_settings();
		// zero threshold trips everything
		write_reg(REG_THRESHOLD, '0);
		send_scan('0, 1'b0, '0, 1'b0, 1'b1);
		settle();
		// upper data bits of the threshold are dropped
		write_reg(REG_SCALE, 24'hFFFFFF);
		write_reg(REG_THRESHOLD, 24'hFFFFFF);
		send_scan(SAMPLE_MAX, 1'b0, 12'd1, 1'b0, 1'b1);
		settle();
		write_reg(REG_SCALE, '0);
		send_scan(SAMPLE_MAX, 1'b0, SAMPLE_MAX, 1'b0, 1'b1);
		settle();
		// exact halves round up
		write_reg(REG_SCALE, 24'h008000);
		send_scan(12'd1, 1'b0, 12'd3, 1'b0, 1'b1);
		settle();
		write_reg(REG_SCALE, 24'd1);
		send_scan(SAMPLE_MAX, 1'b0, SAMPLE_MAX, 1'b0, 1'b1);
		settle();
		write_reg(REG_SCALE, CFG_DATA_W'(SCALE_RST));
		write_reg(REG_THRESHOLD, 24'd1000);
		send_scan(12'd999, 1'b0, 12'd1000, 1'b0, 1'b1);
		settle();
		// writes to unused indexes must change nothing
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '0);
		send_scan(12'd1000, 1'b0, 12'd999, 1'b0, 1'b1);
		settle();
		write_reg(REG_THRESHOLD, CFG_DATA_W'(THRESHOLD_RST));
	endtask

	task automatic test_overlong_burst();
		logic [SAMPLE_W-1:0] late_a;
		// samples past the limit would pull channel a down
		for (int i = 0; i < MAX_SAMPLES_DEF + 8; i++) begin
			late_a = (i < MAX_SAMPLES_DEF) ? SAMPLE_MAX : '0;
			send_scan(late_a, 1'b0, SAMPLE_W'(i * 37), i[0], i == MAX_SAMPLES_DEF + 7);
		end
		for (int i = 0; i < MAX_SAMPLES_DEF + 3; i++)
			send_scan(SAMPLE_W'(i), 1'b0, (i < MAX_SAMPLES_DEF) ? 12'd10 : SAMPLE_MAX, 1'b0,
				i == MAX_SAMPLES_DEF + 2);
		settle();
	endtask

	task automatic test_output_hold_off();
		hold_request = 1'b1;
		while (!hold_active) @(posedge clk);
		// keep offering short bursts so the block backs up into its input
		for (int i = 0; i < 5; i++)
			send_burst(2, 0, 0);
		settle();
	endtask

	task automatic test_random_bursts();
		int sent;
		int len;
		logic [CFG_DATA_W-1:0] scale;
		logic [CFG_DATA_W-1:0] thr;
		for (int phase = 0; phase < 5; phase++) begin
			case ($urandom_range(0, 5))
				0: scale = $urandom_range(0, 24'hFFFFFF);
				1: scale = 24'hFFFFFF;
				default: scale = $urandom_range(1 << 14, 1 << 20);
			endcase
			case ($urandom_range(0, 5))
				0: thr = '0;
				1: thr = CFG_DATA_W'(THRESHOLD_RST);
				default: thr = $urandom_range(0, 40000);
			endcase
			write_reg(REG_SCALE, scale);
			write_reg(REG_THRESHOLD, thr);
			// no idling in the final phase
			tx_idling = (phase < 4);
			rx_idling = (phase < 4);
			sent = 0;
			while (sent < 65) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(MAX_SAMPLES_DEF - 4,
					MAX_SAMPLES_DEF + 11) : $urandom_range(1, 8);
				send_burst(len, pick_error_rate(), pick_error_rate());
				sent += len;
			end
			tx_idling = 1'b0;
			rx_idling = 1'b0;
			settle();
		end
	endtask

	// receiver side: random stall bursts plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_OFF_CYCLES;
			end else if (rx_idling && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8);
			end
			hold_active = (stall_left > 8);
			out_stall <= (stall_left > 0);
		end
	end

	always @(posedge clk) begin
		burst_report_t want;
		burst_report_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.current_a = current_a_ma;
			got.current_b = current_b_ma;
			got.trip_a    = trip_a;
			got.trip_b    = trip_b;
			reports_checked++;
			trips_seen += got.trip_a + got.trip_b;
			saturated_seen += (got.current_a == CURRENT_SAT) + (got.current_b == CURRENT_SAT);
			if (expected_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTED)
					$display("%0t unexpected word: cur_a=%0d cur_b=%0d trip_a=%0b trip_b=%0b",
						$time, got.current_a, got.current_b, got.trip_a, got.trip_b);
			end else begin
				want = expected_reports.pop_front();
				if (got.current_a !== want.current_a || got.current_b !== want.current_b ||
						got.trip_a !== want.trip_a || got.trip_b !== want.trip_b) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTED) begin
						$display("%0t mismatch: expected cur_a=%0d cur_b=%0d trip_a=%0b trip_b=%0b",
							$time, want.current_a, want.current_b, want.trip_a, want.trip_b);
						$display("    got cur_a=%0d cur_b=%0d trip_a=%0b trip_b=%0b",
							got.current_a, got.current_b, got.trip_a, got.trip_b);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (in_valid && in_stall)
				in_stall_cycles++;
		end
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_SCALE;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		sample_a  <= '0;
		error_a   <= 1'b0;
		sample_b  <= '0;
		error_b   <= 1'b0;
		burst_end <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_register_settings();
		test_overlong_burst();
		test_output_hold_off();
		test_random_bursts();
		settle();
		if (expected_reports.size() != 0) begin
			mismatch_count += expected_reports.size();
			$display("%0d expected words never arrived", expected_reports.size());
		end
		$display("sent %0d scans, checked %0d burst results (%0d trip flags, %0d saturated)",
			scans_sent, reports_checked, trips_seen, saturated_seen);
		$display("input held off %0d cycles, one output hold-off of %0d cycles, %0d mismatches",
			in_stall_cycles, HOLD_OFF_CYCLES, mismatch_count);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
